// ===== hw/rtl/hbbc_pkg.sv =====
// Package for the hashed block buffer cache.
// Holds request and status codes, field widths and the buffer entry layout.
// No dependencies.
package hbbc_pkg;

    // Field widths of the stream words
    localparam int DEV_W     = 8;
    localparam int BLK_W     = 32;
    localparam int SLOT_W    = 5;
    localparam int CNT_W     = 8;
    localparam int REQ_W     = 2;
    localparam int STAT_W    = 2;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 16;

    localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

    typedef enum logic [REQ_W-1:0] {
        REQ_GET     = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_PIN     = 2'd2,
        REQ_UNPIN   = 2'd3
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_FREE   = 2'd1,
        STAT_UNDERFLOW = 2'd2,
        STAT_RSVD      = 2'd3
    } status_t;

    // One buffer's tags, reference count and contents-valid bit
    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] cnt;
        logic [BLK_W-1:0] blk;
        logic [DEV_W-1:0] dev;
    } buf_entry_t;

endpackage

// ===== hw/rtl/hbbc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module hbbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/hbbc_mod.sv =====
// Reduction of a block number modulo the bucket count in three pipelined steps:
// byte folding, a reciprocal multiply for the quotient, then a subtract. Depends on hbbc_pkg.
module hbbc_mod #(
    parameter int NUM_BUCKETS = 13
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [hbbc_pkg::BLK_W-1:0]  block,
    output logic                        done,
    output logic [((NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1)-1:0] bucket
);

    localparam int KW  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int SW  = 16;
    localparam int SH  = 24;
    localparam int RCW = SH + 1;
    localparam int PW  = SW + RCW;
    // weight of each byte: 256^k mod NUM_BUCKETS
    localparam logic [SW-1:0] C0 = SW'(1 % NUM_BUCKETS);
    localparam logic [SW-1:0] C1 = SW'((1 << 8) % NUM_BUCKETS);
    localparam logic [SW-1:0] C2 = SW'((1 << 16) % NUM_BUCKETS);
    localparam logic [SW-1:0] C3 = SW'((1 << 24) % NUM_BUCKETS);
    // ceil(2^24 / NUM_BUCKETS), exact quotient for any folded sum below 2^16
    localparam logic [RCW-1:0] RECIP = RCW'(((1 << SH) + NUM_BUCKETS - 1) / NUM_BUCKETS);
    localparam logic [SW-1:0]  MODV  = SW'(NUM_BUCKETS);

    logic [SW-1:0]  fold;
    logic [SW-1:0]  sum_reg;
    logic [SW-1:0]  sum2_reg;
    logic [SW-1:0]  quot_reg;
    logic [KW-1:0]  rem_reg;
    logic [PW-1:0]  prod;
    logic [SW-1:0]  qm;
    logic [SW-1:0]  diff;
    logic           v1_reg;
    logic           v2_reg;
    logic           done_reg;

    // byte fold keeps the residue and stays below 2^16
    assign fold = SW'(block[7:0]) * C0 + SW'(block[15:8]) * C1
                + SW'(block[23:16]) * C2 + SW'(block[31:24]) * C3;
    assign prod = PW'(sum_reg) * PW'(RECIP);
    assign qm   = quot_reg * MODV;
    assign diff = sum2_reg - qm;

    // step valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            sum_reg <= fold;
        end
        if (v1_reg) begin
            quot_reg <= prod[SH +: SW];
            sum2_reg <= sum_reg;
        end
        if (v2_reg) begin
            rem_reg <= diff[KW-1:0];
        end
    end

    assign done   = done_reg;
    assign bucket = rem_reg;

endmodule

// ===== hw/rtl/hashed_block_buffer_cache.sv =====
// Hashed block buffer cache: buffer tags and counts in one RAM, bucket list links
// in a second RAM; a sequencer walks the lists. Depends on hbbc_pkg, hbbc_ram, hbbc_mod.
//
// One word in, one word out. After reset a clearing pass over all NUM_BUFFERS+NUM_BUCKETS
// link entries writes the initial tags and lists; no word is taken during it. Release,
// pin and unpin read the buffer entry, write it back and then output. A get first reduces
// the block number modulo NUM_BUCKETS in a pipeline (byte fold, reciprocal multiply,
// subtract), then walks its bucket one node per cycle through the link RAM read port,
// head first. A miss then scans the buckets from bucket 0, each bucket head and then its
// nodes, and moving the chosen buffer into another bucket runs link RAM read-modify-write
// states S_UWP, S_URQ, S_UWQ, S_PWH and S_PWN, plus a final write to the old first node
// when the target bucket is not empty. The next word is taken in the cycle after the
// result enters the output register.
module hashed_block_buffer_cache #(
    parameter int NUM_BUFFERS = 32,
    parameter int NUM_BUCKETS = 13
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // device_id [7:0], block_number [39:8], slot [44:40]
    input  logic [hbbc_pkg::S_TDATA_W-1:0]   s_tdata,
    // req_type [1:0]
    input  logic [hbbc_pkg::REQ_W-1:0]       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // buffer_slot [4:0], hit [5], fill_needed [6], status [8:7]
    output logic [hbbc_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int NUM_NODES = NUM_BUFFERS + NUM_BUCKETS;
    localparam int BW = $clog2(NUM_BUFFERS);
    localparam int NW = $clog2(NUM_NODES);
    localparam int KW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam logic [NW-1:0] HEAD0 = NW'(NUM_BUFFERS);
    localparam logic [NW-1:0] LASTB = NW'(NUM_BUFFERS - 1);
    localparam logic [NW-1:0] LASTN = NW'(NUM_NODES - 1);
    localparam logic [KW-1:0] LASTK = KW'(NUM_BUCKETS - 1);

    typedef struct packed {
        logic [NW-1:0] prev;
        logic [NW-1:0] nxt;
    } link_t;

    typedef enum logic [12:0] {
        S_INIT  = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_SUPD  = 13'b0000000000100,
        S_MOD   = 13'b0000000001000,
        S_HFST  = 13'b0000000010000,
        S_HCHK  = 13'b0000000100000,
        S_SFST  = 13'b0000001000000,
        S_SCHK  = 13'b0000010000000,
        S_UWP   = 13'b0000100000000,
        S_URQ   = 13'b0001000000000,
        S_UWQ   = 13'b0010000000000,
        S_PWH   = 13'b0100000000000,
        S_PWN   = 13'b1000000000000
    } state_t;

    // extra states for the final link write and the result hand-off, kept outside the main one-hot group
    logic pwf_reg, pwf_next;
    logic done_st_reg, done_st_next;

    state_t state_reg, state_next;

    // request
    hbbc_pkg::req_t              req_reg, req_next;
    logic [hbbc_pkg::DEV_W-1:0]  dev_reg, dev_next;
    logic [hbbc_pkg::BLK_W-1:0]  blk_reg, blk_next;
    logic [hbbc_pkg::SLOT_W-1:0] slot_reg, slot_next;

    // walk state
    logic [NW-1:0] node_reg, node_next;
    logic [NW-1:0] p_reg, p_next;
    logic [NW-1:0] q_reg, q_next;
    logic [NW-1:0] first_reg, first_next;
    logic [KW-1:0] bkt_reg, bkt_next;
    logic [KW-1:0] scan_reg, scan_next;
    logic [NW-1:0] init_reg, init_next;

    // pending result
    logic [hbbc_pkg::SLOT_W-1:0] rslot_reg, rslot_next;
    logic                        rhit_reg, rhit_next;
    logic                        rfill_reg, rfill_next;
    hbbc_pkg::status_t           rstat_reg, rstat_next;

    // output register
    logic                          mvalid_reg, mvalid_next;
    logic [hbbc_pkg::M_TDATA_W-1:0] mdata_reg, mdata_next;

    // memories
    logic                    buf_we;
    logic [BW-1:0]           buf_waddr, buf_raddr;
    hbbc_pkg::buf_entry_t    buf_wdata, buf_rdata;
    logic                    lnk_we;
    logic [NW-1:0]           lnk_waddr, lnk_raddr;
    link_t                   lnk_wdata, lnk_rdata;

    logic          mod_start, mod_done;
    logic [KW-1:0] mod_bucket;

    logic [hbbc_pkg::SLOT_W-1:0] in_slot;
    logic [hbbc_pkg::BLK_W-1:0]  in_blk;
    logic [hbbc_pkg::DEV_W-1:0]  in_dev;
    logic                        accept;
    logic                        out_free;
    logic                        tag_match;
    logic [NW-1:0]               tgt_head;
    logic [NW-1:0]               scan_head_n;

    assign in_dev  = s_tdata[7:0];
    assign in_blk  = s_tdata[39:8];
    assign in_slot = s_tdata[44:40];

    assign s_tready    = (state_reg == S_IDLE) && !pwf_reg && !done_st_reg;
    assign accept      = s_tvalid && s_tready;
    assign out_free    = !mvalid_reg || m_tready;
    assign tag_match   = (buf_rdata.dev == dev_reg) && (buf_rdata.blk == blk_reg);
    assign tgt_head    = HEAD0 + NW'(bkt_reg);
    assign scan_head_n = HEAD0 + NW'(scan_reg) + 1'b1;

    hbbc_ram #(.WIDTH($bits(hbbc_pkg::buf_entry_t)), .DEPTH(NUM_BUFFERS)) u_buf_ram (
        .aclk  (aclk),
        .we    (buf_we),
        .waddr (buf_waddr),
        .wdata (buf_wdata),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    hbbc_ram #(.WIDTH(2 * NW), .DEPTH(NUM_NODES)) u_link_ram (
        .aclk  (aclk),
        .we    (lnk_we),
        .waddr (lnk_waddr),
        .wdata (lnk_wdata),
        .raddr (lnk_raddr),
        .rdata (lnk_rdata)
    );

    hbbc_mod #(.NUM_BUCKETS(NUM_BUCKETS)) u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mod_start),
        .block   (in_blk),
        .done    (mod_done),
        .bucket  (mod_bucket)
    );

    // sequencer
    always_comb begin
        state_next   = state_reg;
        pwf_next     = 1'b0;
        done_st_next = done_st_reg;
        req_next     = req_reg;
        dev_next     = dev_reg;
        blk_next     = blk_reg;
        slot_next    = slot_reg;
        node_next    = node_reg;
        p_next       = p_reg;
        q_next       = q_reg;
        first_next   = first_reg;
        bkt_next     = bkt_reg;
        scan_next    = scan_reg;
        init_next    = init_reg;
        rslot_next   = rslot_reg;
        rhit_next    = rhit_reg;
        rfill_next   = rfill_reg;
        rstat_next   = rstat_reg;
        mvalid_next  = mvalid_reg;
        mdata_next   = mdata_reg;
        buf_we       = 1'b0;
        buf_waddr    = node_reg[BW-1:0];
        buf_wdata    = buf_rdata;
        buf_raddr    = node_reg[BW-1:0];
        lnk_we       = 1'b0;
        lnk_waddr    = node_reg;
        lnk_wdata    = lnk_rdata;
        lnk_raddr    = node_reg;
        mod_start    = 1'b0;

        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end

        if (done_st_reg) begin
            // hand the pending result to the output register
            if (out_free) begin
                mvalid_next  = 1'b1;
                mdata_next   = hbbc_pkg::M_TDATA_W'({rstat_reg, rfill_reg, rhit_reg,
                                                     rslot_reg});
                done_st_next = 1'b0;
            end
        end else if (pwf_reg) begin
            // first node of the target bucket points back to the moved buffer
            lnk_we       = 1'b1;
            lnk_waddr    = first_reg;
            lnk_wdata    = '{prev: node_reg, nxt: lnk_rdata.nxt};
            done_st_next = 1'b1;
        end else begin
            case (state_reg)
                S_INIT: begin
                    // clearing pass: initial tags, the list of bucket zero and empty lists for the other buckets
                    lnk_we    = 1'b1;
                    lnk_waddr = init_reg;
                    if (init_reg < HEAD0) begin
                        lnk_wdata.nxt  = (init_reg == '0) ? HEAD0 : init_reg - 1'b1;
                        lnk_wdata.prev = (init_reg == LASTB) ? HEAD0 : init_reg + 1'b1;
                        buf_we    = 1'b1;
                        buf_waddr = init_reg[BW-1:0];
                        buf_wdata = '0;
                    end else if (init_reg == HEAD0) begin
                        lnk_wdata.nxt  = LASTB;
                        lnk_wdata.prev = '0;
                    end else begin
                        lnk_wdata.nxt  = init_reg;
                        lnk_wdata.prev = init_reg;
                    end
                    init_next = init_reg + 1'b1;
                    if (init_reg == LASTN) begin
                        state_next = S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        req_next   = hbbc_pkg::req_t'(s_tuser);
                        dev_next   = in_dev;
                        blk_next   = in_blk;
                        slot_next  = in_slot;
                        rslot_next = in_slot;
                        rhit_next  = 1'b0;
                        rfill_next = 1'b0;
                        rstat_next = hbbc_pkg::STAT_OK;
                        buf_raddr  = BW'(in_slot);
                        if (hbbc_pkg::req_t'(s_tuser) == hbbc_pkg::REQ_GET) begin
                            mod_start  = 1'b1;
                            state_next = S_MOD;
                        end else if (32'(in_slot) < 32'(NUM_BUFFERS)) begin
                            state_next = S_SUPD;
                        end else begin
                            done_st_next = 1'b1;
                        end
                    end
                end
                S_SUPD: begin
                    // count update for release, pin and unpin
                    buf_we    = 1'b1;
                    buf_waddr = BW'(slot_reg);
                    if (req_reg == hbbc_pkg::REQ_PIN) begin
                        if (buf_rdata.cnt != hbbc_pkg::CNT_MAX) begin
                            buf_wdata.cnt = buf_rdata.cnt + 1'b1;
                        end
                    end else if (buf_rdata.cnt == '0) begin
                        rstat_next = hbbc_pkg::STAT_UNDERFLOW;
                    end else begin
                        buf_wdata.cnt = buf_rdata.cnt - 1'b1;
                    end
                    state_next   = S_IDLE;
                    done_st_next = 1'b1;
                end
                S_MOD: begin
                    if (mod_done) begin
                        bkt_next   = mod_bucket;
                        lnk_raddr  = HEAD0 + NW'(mod_bucket);
                        state_next = S_HFST;
                    end
                end
                S_HFST, S_HCHK: begin
                    // hit search down the target bucket
                    if (state_reg == S_HCHK && tag_match) begin
                        buf_we = 1'b1;
                        if (buf_rdata.cnt != hbbc_pkg::CNT_MAX) begin
                            buf_wdata.cnt = buf_rdata.cnt + 1'b1;
                        end
                        buf_wdata.valid = 1'b1;
                        rfill_next   = !buf_rdata.valid;
                        rhit_next    = 1'b1;
                        rslot_next   = hbbc_pkg::SLOT_W'(node_reg[BW-1:0]);
                        state_next   = S_IDLE;
                        done_st_next = 1'b1;
                    end else if (lnk_rdata.nxt >= HEAD0) begin
                        scan_next  = '0;
                        lnk_raddr  = HEAD0;
                        state_next = S_SFST;
                    end else begin
                        node_next  = lnk_rdata.nxt;
                        buf_raddr  = lnk_rdata.nxt[BW-1:0];
                        lnk_raddr  = lnk_rdata.nxt;
                        state_next = S_HCHK;
                    end
                end
                S_SFST, S_SCHK: begin
                    // free buffer scan, buckets in ascending order
                    if (state_reg == S_SCHK && buf_rdata.cnt == '0) begin
                        buf_we       = 1'b1;
                        buf_wdata    = '{valid: 1'b1, cnt: hbbc_pkg::CNT_W'(1),
                                         blk: blk_reg, dev: dev_reg};
                        rfill_next   = 1'b1;
                        rslot_next   = hbbc_pkg::SLOT_W'(node_reg[BW-1:0]);
                        p_next       = lnk_rdata.prev;
                        q_next       = lnk_rdata.nxt;
                        if (scan_reg == bkt_reg) begin
                            state_next   = S_IDLE;
                            done_st_next = 1'b1;
                        end else begin
                            lnk_raddr  = lnk_rdata.prev;
                            state_next = S_UWP;
                        end
                    end else if (lnk_rdata.nxt >= HEAD0) begin
                        if (scan_reg == LASTK) begin
                            rstat_next   = hbbc_pkg::STAT_NO_FREE;
                            rslot_next   = '0;
                            state_next   = S_IDLE;
                            done_st_next = 1'b1;
                        end else begin
                            scan_next  = scan_reg + 1'b1;
                            lnk_raddr  = scan_head_n;
                            state_next = S_SFST;
                        end
                    end else begin
                        node_next  = lnk_rdata.nxt;
                        buf_raddr  = lnk_rdata.nxt[BW-1:0];
                        lnk_raddr  = lnk_rdata.nxt;
                        state_next = S_SCHK;
                    end
                end
                S_UWP: begin
                    // unlink: predecessor skips the buffer
                    lnk_we     = 1'b1;
                    lnk_waddr  = p_reg;
                    lnk_wdata  = '{prev: lnk_rdata.prev, nxt: q_reg};
                    state_next = S_URQ;
                end
                S_URQ: begin
                    lnk_raddr  = q_reg;
                    state_next = S_UWQ;
                end
                S_UWQ: begin
                    // unlink: successor points back past the buffer
                    lnk_we     = 1'b1;
                    lnk_waddr  = q_reg;
                    lnk_wdata  = '{prev: p_reg, nxt: lnk_rdata.nxt};
                    lnk_raddr  = tgt_head;
                    state_next = S_PWH;
                end
                S_PWH: begin
                    // push front: head now points to the buffer
                    first_next = lnk_rdata.nxt;
                    lnk_we     = 1'b1;
                    lnk_waddr  = tgt_head;
                    lnk_wdata  = '{prev: (lnk_rdata.nxt == tgt_head) ? node_reg
                                                                     : lnk_rdata.prev,
                                   nxt: node_reg};
                    state_next = S_PWN;
                end
                S_PWN: begin
                    lnk_we     = 1'b1;
                    lnk_waddr  = node_reg;
                    lnk_wdata  = '{prev: tgt_head, nxt: first_reg};
                    lnk_raddr  = first_reg;
                    state_next = S_IDLE;
                    if (first_reg == tgt_head) begin
                        done_st_next = 1'b1;
                    end else begin
                        pwf_next = 1'b1;
                    end
                end
                default: begin
                    state_next = S_INIT;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            pwf_reg     <= 1'b0;
            done_st_reg <= 1'b0;
            init_reg    <= '0;
            mvalid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pwf_reg     <= pwf_next;
            done_st_reg <= done_st_next;
            init_reg    <= init_next;
            mvalid_reg  <= mvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        req_reg   <= req_next;
        dev_reg   <= dev_next;
        blk_reg   <= blk_next;
        slot_reg  <= slot_next;
        node_reg  <= node_next;
        p_reg     <= p_next;
        q_reg     <= q_next;
        first_reg <= first_next;
        bkt_reg   <= bkt_next;
        scan_reg  <= scan_next;
        rslot_reg <= rslot_next;
        rhit_reg  <= rhit_next;
        rfill_reg <= rfill_next;
        rstat_reg <= rstat_next;
        mdata_reg <= mdata_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

endmodule

// ===== hw/rtl/hbbc_checker.sv =====
// Port-level checks for the hashed block buffer cache, bound to the top level.
// Depends on hbbc_pkg.
module hbbc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [hbbc_pkg::M_TDATA_W-1:0] m_tdata
);

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // only defined status codes
    a_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[8:7] != hbbc_pkg::STAT_RSVD)
        else $error("undefined status");

    // a hit is always a successful get
    a_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[5] |-> m_tdata[8:7] == hbbc_pkg::STAT_OK)
        else $error("hit with error status");

    // no free buffer returns slot zero and no flags
    a_nofree: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8:7] == hbbc_pkg::STAT_NO_FREE |->
        m_tdata[6:0] == 7'd0)
        else $error("no-free result carries data");

    // underflow never reports a hit or a fill
    a_under: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8:7] == hbbc_pkg::STAT_UNDERFLOW |->
        m_tdata[6:5] == 2'd0)
        else $error("underflow with get flags");

endmodule

bind hashed_block_buffer_cache hbbc_checker u_hbbc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
